/* design/dprmv_pkg.sv */
package dprmv_pkg;

   // Request selector codes
   localparam logic [1:0] ActLoad  = 2'd0;
   localparam logic [1:0] ActQuery = 2'd1;
   localparam logic [1:0] ActClear = 2'd2;

   // Result kinds
   localparam logic KindLoad  = 1'b0;
   localparam logic KindQuery = 1'b1;

   // Status codes
   localparam logic [1:0] StOk   = 2'd0;
   localparam logic [1:0] StFull = 2'd1;
   localparam logic [1:0] StLong = 2'd2;

   // Fixed field widths shared by the cells, sized for the largest pool and descriptor
   localparam int NumSearch = 4;
   localparam int IdxBits   = 10;
   localparam int FillBits  = 11;
   localparam int AddrBits  = 8;
   localparam int AccBits   = 32;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ACC,
      ST_SCAN,
      ST_RATIO,
      ST_VOTE
   } state_type;

   // Nearest and second-nearest record for one search
   typedef struct packed {
      logic               have0;
      logic               have1;
      logic [AccBits-1:0] d0;
      logic [AccBits-1:0] d1;
      logic [IdxBits-1:0] best;
   } search_rec_type;

   typedef search_rec_type [NumSearch-1:0] rec_set_type;

   // Control broadcast from the controller to every cell
   typedef struct packed {
      logic                wr_en;
      logic [IdxBits-1:0]  wr_entry;
      logic [AddrBits-1:0] wr_addr;
      logic [11:0]         wr_left;
      logic [11:0]         wr_right;
      logic [AddrBits-1:0] rd_addr;
      logic                acc_en;
      logic                acc_fresh;
      logic                acc_use;
      logic [11:0]         q_left;
      logic [11:0]         q_right;
   } cell_ctl_type;

   typedef struct packed {
      logic       accepted;
      logic [5:0] pool_index;
      logic [2:0] vote_count;
      logic [2:0] searches_matched;
   } vote_result_type;

endpackage

/* design/dprmv_cell.sv */
module dprmv_cell
   import dprmv_pkg::*;
#(
   parameter int DESC_MAX = 128,
   parameter int CELL_ID  = 0
) (
   input  logic                clock,
   input  logic                reset,
   input  cell_ctl_type        ctl,
   input  logic [FillBits-1:0] fill,
   input  rec_set_type         rec_i,
   input  logic                rec_valid_i,
   output rec_set_type         rec_o,
   output logic                rec_valid_o
);

   localparam int AW = (DESC_MAX > 1) ? $clog2(DESC_MAX) : 1;

   logic [23:0]        mem [DESC_MAX];
   logic [23:0]        rd_ff;
   logic [AccBits-1:0] acc_ff [NumSearch];
   logic [AccBits-1:0] acc_in [NumSearch];
   logic signed [12:0] diff [NumSearch];
   logic signed [25:0] prod [NumSearch];
   rec_set_type        rec_ff;
   rec_set_type        rec_in;
   logic               valid_ff;
   logic               active;

   // Store this entry's elements, read the element at the query position
   always_ff @(posedge clock) begin
      if (ctl.wr_en && ctl.wr_entry == IdxBits'(CELL_ID)) begin
         mem[ctl.wr_addr[AW-1:0]] <= {ctl.wr_right, ctl.wr_left};
      end
      rd_ff <= mem[ctl.rd_addr[AW-1:0]];
   end

   // Squared differences for the four pairings
   always_comb begin
      diff[0] = $signed({ctl.q_left[11], ctl.q_left})   - $signed({rd_ff[11], rd_ff[11:0]});
      diff[1] = $signed({ctl.q_left[11], ctl.q_left})   - $signed({rd_ff[23], rd_ff[23:12]});
      diff[2] = $signed({ctl.q_right[11], ctl.q_right}) - $signed({rd_ff[11], rd_ff[11:0]});
      diff[3] = $signed({ctl.q_right[11], ctl.q_right}) - $signed({rd_ff[23], rd_ff[23:12]});
      for (int k = 0; k < NumSearch; k++) begin
         prod[k]   = diff[k] * diff[k];
         acc_in[k] = (ctl.acc_fresh ? '0 : acc_ff[k])
                   + (ctl.acc_use ? AccBits'($unsigned(prod[k])) : '0);
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.acc_en) begin
         for (int k = 0; k < NumSearch; k++) begin
            acc_ff[k] <= acc_in[k];
         end
      end
   end

   // Fold this entry into the passing nearest records
   assign active = FillBits'(CELL_ID) < fill;

   always_comb begin
      rec_in = rec_i;
      if (active) begin
         for (int k = 0; k < NumSearch; k++) begin
            if (!rec_i[k].have0 || acc_ff[k] < rec_i[k].d0) begin
               rec_in[k].d1    = rec_i[k].d0;
               rec_in[k].have1 = rec_i[k].have0;
               rec_in[k].d0    = acc_ff[k];
               rec_in[k].have0 = 1'b1;
               rec_in[k].best  = IdxBits'(CELL_ID);
            end else if (!rec_i[k].have1 || acc_ff[k] < rec_i[k].d1) begin
               rec_in[k].d1    = acc_ff[k];
               rec_in[k].have1 = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rec_valid_i) begin
         rec_ff <= rec_in;
      end
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= rec_valid_i;
      end
   end

   assign rec_o       = rec_ff;
   assign rec_valid_o = valid_ff;

endmodule

/* design/dprmv_vote.sv */
module dprmv_vote
   import dprmv_pkg::*;
(
   input  logic            clock,
   input  rec_set_type     recs,
   input  logic [15:0]     ratio_sq,
   input  logic            load_en,
   output vote_result_type result
);

   logic [47:0]        prod_ff [NumSearch];
   logic [AccBits-1:0] d0_ff   [NumSearch];
   logic               have0_ff [NumSearch];
   logic               have1_ff [NumSearch];
   logic [IdxBits-1:0] id_ff   [NumSearch];
   logic               ratio_nz_ff;
   logic               match [NumSearch];
   logic [2:0]         matched;
   logic [2:0]         cnt;
   logic [2:0]         win_cnt;
   logic [IdxBits-1:0] win_id;
   logic               have_win;

   // Register the threshold products of the second distances
   always_ff @(posedge clock) begin
      if (load_en) begin
         for (int k = 0; k < NumSearch; k++) begin
            prod_ff[k]  <= 48'(recs[k].d1) * 48'(ratio_sq);
            d0_ff[k]    <= recs[k].d0;
            have0_ff[k] <= recs[k].have0;
            have1_ff[k] <= recs[k].have1;
            id_ff[k]    <= recs[k].best;
         end
         ratio_nz_ff <= ratio_sq != 16'd0;
      end
   end

   // Ratio test, then majority vote with the lower index winning ties
   always_comb begin
      matched  = '0;
      win_cnt  = '0;
      win_id   = '0;
      have_win = 1'b0;
      for (int s = 0; s < NumSearch; s++) begin
         match[s] = have0_ff[s] &&
                    (have1_ff[s] ? ({d0_ff[s], 16'd0} < prod_ff[s]) : ratio_nz_ff);
         matched  = matched + 3'(match[s]);
      end
      for (int s = 0; s < NumSearch; s++) begin
         cnt = '0;
         for (int t = 0; t < NumSearch; t++) begin
            cnt = cnt + 3'(match[t] && id_ff[t] == id_ff[s]);
         end
         if (match[s] && (!have_win || cnt > win_cnt ||
                          (cnt == win_cnt && id_ff[s] < win_id))) begin
            have_win = 1'b1;
            win_cnt  = cnt;
            win_id   = id_ff[s];
         end
      end
      result.accepted         = matched >= 3'd2 && {win_cnt, 1'b0} > {1'b0, matched};
      result.pool_index       = win_id[5:0];
      result.vote_count       = win_cnt;
      result.searches_matched = matched;
   end

endmodule

/* design/descriptor_pool_ratio_match_vote.sv */
// Channel  Direction  Handshake             Payload
// req      in         req_tvalid/req_tready tdata {right, left}, tuser action, tlast last
// rsp      out        rsp_tvalid/rsp_tready tdata {status, matched, votes, index, accepted}, tuser kind
// csr      in         csr_valid/csr_ready   csr_data ratio_sq
//
// Load, clear and non-final query elements are taken back to back while the response is free.
// For the final query element the distances are accumulated, then the nearest records travel
// the cell chain one cell per cycle, then ratio and vote stages register its result once rsp is free.
// Synchronous reset empties the pool and restarts the position; stored elements are not cleared.
// req_tready drops while a query is searched and while a result waits untaken.
module descriptor_pool_ratio_match_vote
   import dprmv_pkg::*;
#(
   parameter int POOL_SIZE = 64,
   parameter int DESC_MAX  = 128
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // [11:0] left_value, [23:12] right_value
   input  logic [1:0]  req_tuser,   // [1:0] action
   input  logic        req_tlast,   // last_element
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [0] accepted, [6:1] pool_index, [9:7] vote_count,
                                    // [12:10] searches_matched, [14:13] status, [15] zero
   output logic        rsp_tuser,   // [0] kind
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_data     // ratio_sq
);

   localparam int PW = $clog2(DESC_MAX + 1);
   localparam int FW = $clog2(POOL_SIZE + 1);

   state_type       state_ff, state_in;
   logic [PW-1:0]   pos_ff, pos_in;
   logic [FW-1:0]   fill_ff, fill_in;
   logic            ovl_ff, ovl_in;
   logic            zero_ff, zero_in;
   logic            q_ovl_ff;
   logic [15:0]     ratio_ff;
   logic            acc_en_ff, fresh_ff, use_ff;
   logic [11:0]     ql_ff, qr_ff;
   logic            chain_start_ff;
   logic            rsp_valid_ff;
   logic            rsp_kind_ff;
   logic [14:0]     rsp_data_ff;

   logic            accept, pos_lt, full, rsp_free, vote_load, ratio_load;
   logic            is_load, is_query, is_clear;
   cell_ctl_type    ctl;
   rec_set_type     rec_chain [POOL_SIZE+1];
   logic            valid_chain [POOL_SIZE+1];
   vote_result_type vote;

   assign rsp_free = !rsp_valid_ff || rsp_tready;
   assign accept   = req_tvalid && req_tready;
   assign is_load  = req_tuser == ActLoad;
   assign is_query = req_tuser == ActQuery;
   assign is_clear = req_tuser == ActClear;
   assign pos_lt   = pos_ff < PW'(DESC_MAX);
   assign full     = fill_ff >= FW'(POOL_SIZE);

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (accept && is_query && req_tlast) state_in = ST_ACC;
         ST_ACC:   state_in = ST_SCAN;
         ST_SCAN:  if (valid_chain[POOL_SIZE]) state_in = ST_RATIO;
         ST_RATIO: state_in = ST_VOTE;
         ST_VOTE:  if (rsp_free) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // State outputs
   always_comb begin
      req_tready = 1'b0;
      ratio_load = 1'b0;
      vote_load  = 1'b0;
      unique case (state_ff)
         ST_IDLE:  req_tready = rsp_free;
         ST_RATIO: ratio_load = 1'b1;
         ST_VOTE:  vote_load  = rsp_free;
         default:  req_tready = 1'b0;
      endcase
   end

   // Position, fill and flag updates per request
   always_comb begin
      pos_in  = pos_ff;
      fill_in = fill_ff;
      ovl_in  = ovl_ff;
      zero_in = zero_ff;
      if (accept) begin
         if (is_clear) begin
            pos_in  = '0;
            fill_in = '0;
            ovl_in  = 1'b0;
            zero_in = 1'b1;
         end else if (is_load || is_query) begin
            if (req_tlast) begin
               pos_in = '0;
               ovl_in = 1'b0;
            end else begin
               pos_in = pos_ff + PW'(pos_lt);
               ovl_in = ovl_ff || !pos_lt;
            end
            if (is_load && req_tlast && !full) begin
               fill_in = fill_ff + FW'(1);
            end
            if (is_query) begin
               zero_in = req_tlast;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         pos_ff         <= '0;
         fill_ff        <= '0;
         ovl_ff         <= 1'b0;
         zero_ff        <= 1'b1;
         ratio_ff       <= 16'd27689;
         acc_en_ff      <= 1'b0;
         chain_start_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         pos_ff         <= pos_in;
         fill_ff        <= fill_in;
         ovl_ff         <= ovl_in;
         zero_ff        <= zero_in;
         acc_en_ff      <= accept && is_query;
         chain_start_ff <= state_ff == ST_ACC;
         if (csr_valid) begin
            ratio_ff <= csr_data;
         end
         if ((accept && is_load && req_tlast) || vote_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Hold the query element for the accumulate stage, and the result payload
   always_ff @(posedge clock) begin
      if (accept && is_query) begin
         fresh_ff <= pos_ff == '0 || zero_ff;
         use_ff   <= pos_lt;
         ql_ff    <= req_tdata[11:0];
         qr_ff    <= req_tdata[23:12];
         if (req_tlast) begin
            q_ovl_ff <= ovl_ff || !pos_lt;
         end
      end
      if (accept && is_load && req_tlast) begin
         rsp_kind_ff <= KindLoad;
         rsp_data_ff <= {full ? StFull : ((ovl_ff || !pos_lt) ? StLong : StOk),
                         3'd0, 3'd0, full ? 6'd0 : 6'(fill_ff), 1'b0};
      end else if (vote_load) begin
         rsp_kind_ff <= KindQuery;
         rsp_data_ff <= {q_ovl_ff ? StLong : StOk, vote.searches_matched,
                         vote.vote_count, vote.pool_index, vote.accepted};
      end
   end

   // Broadcast to the cells
   always_comb begin
      ctl.wr_en     = accept && is_load && !full && pos_lt;
      ctl.wr_entry  = IdxBits'(fill_ff);
      ctl.wr_addr   = AddrBits'(pos_ff);
      ctl.wr_left   = req_tdata[11:0];
      ctl.wr_right  = req_tdata[23:12];
      ctl.rd_addr   = AddrBits'(pos_ff);
      ctl.acc_en    = acc_en_ff;
      ctl.acc_fresh = fresh_ff;
      ctl.acc_use   = use_ff;
      ctl.q_left    = ql_ff;
      ctl.q_right   = qr_ff;
   end

   assign rec_chain[0]   = '0;
   assign valid_chain[0] = chain_start_ff;

   for (genvar i = 0; i < POOL_SIZE; i++) begin : g_cell
      dprmv_cell #(
         .DESC_MAX (DESC_MAX),
         .CELL_ID  (i)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctl         (ctl),
         .fill        (FillBits'(fill_ff)),
         .rec_i       (rec_chain[i]),
         .rec_valid_i (valid_chain[i]),
         .rec_o       (rec_chain[i+1]),
         .rec_valid_o (valid_chain[i+1])
      );
   end

   dprmv_vote u_vote (
      .clock    (clock),
      .recs     (rec_chain[POOL_SIZE]),
      .ratio_sq (ratio_ff),
      .load_en  (ratio_load),
      .result   (vote)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tdata  = {1'b0, rsp_data_ff};
   assign csr_ready  = 1'b1;

`ifndef SYNTHESIS
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FW'(POOL_SIZE))
      else $error("pool fill beyond pool size");
   a_pos_bound: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= PW'(DESC_MAX))
      else $error("element position beyond descriptor length");
   a_chain_in_scan: assert property (@(posedge clock) disable iff (reset)
      valid_chain[POOL_SIZE] |-> state_ff == ST_SCAN)
      else $error("chain finished outside scan");
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_IDLE |-> !req_tready)
      else $error("request taken while searching");
   a_vote_result: assert property (@(posedge clock) disable iff (reset)
      vote_load |=> rsp_tvalid && rsp_tuser == KindQuery)
      else $error("query result not presented");
`endif

endmodule

/* verif/tb_top.sv */
module tb_top;
   import dprmv_pkg::*;

   localparam int PoolSize  = 64;
   localparam int DescMax   = 128;
   localparam logic [1:0] ActSpare = 2'd3;
   localparam int IdleLimit = 5000;
   localparam int DrainWait = 80;
   localparam int HoldCycles = 400;

   typedef struct {
      logic       kind;
      logic       accepted;
      logic [5:0] pool_index;
      logic [2:0] vote_count;
      logic [2:0] searches_matched;
      logic [1:0] status;
   } match_result_type;

   // Pool model, per-entry distances and the queue of expected matches
   class match_scoreboard;
      logic signed [11:0] pool_l[PoolSize*DescMax];
      logic signed [11:0] pool_r[PoolSize*DescMax];
      bit                 written[PoolSize*DescMax];
      logic [31:0]        acc_sum[PoolSize*NumSearch];
      int                 fill;
      int                 pos;
      bit                 overlong;
      logic [15:0]        ratio;
      match_result_type   exp_q[$];
      int                 errors;

      function new();
         foreach (pool_l[i]) begin
            pool_l[i] = '0;
            pool_r[i] = '0;
            written[i] = 0;
         end
         foreach (acc_sum[i]) acc_sum[i] = '0;
         fill = 0;
         pos = 0;
         overlong = 0;
         ratio = 16'd27689;
         errors = 0;
      endfunction

      task report(string what, int got, int want);
         $display("mismatch %s: got %0d expected %0d", what, got, want);
         errors++;
      endtask

      function void clear_dist();
         foreach (acc_sum[i]) acc_sum[i] = '0;
      endfunction

      // Shortest contiguous written prefix over the filled entries
      function int safe_len();
         int m;
         int p;
         m = DescMax;
         for (int j = 0; j < fill; j++) begin
            p = 0;
            while (p < DescMax && written[j*DescMax+p]) p++;
            if (p < m) m = p;
         end
         return m;
      endfunction

      // Nearest entry passing the ratio test, or -1
      function int nearest(int s);
         logic [31:0] d0, d1, d;
         bit          h0, h1;
         int          best;
         d0 = 0; d1 = 0; h0 = 0; h1 = 0; best = -1;
         for (int j = 0; j < fill && j < PoolSize; j++) begin
            d = acc_sum[j*NumSearch+s];
            if (!h0 || d < d0) begin
               d1 = d0; h1 = h0;
               d0 = d; h0 = 1;
               best = j;
            end else if (!h1 || d < d1) begin
               d1 = d; h1 = 1;
            end
         end
         if (!h0) return -1;
         if (!h1) return (ratio != 0) ? best : -1;
         if ({32'd0, d0} * 64'd65536 < {48'd0, ratio} * {32'd0, d1}) return best;
         return -1;
      endfunction

      function logic [31:0] sq(int a, int b);
         int d;
         d = a - b;
         return d * d;
      endfunction

      // Advance the model by one accepted request
      function void note(logic [1:0] act, logic signed [11:0] lv, logic signed [11:0] rv,
                         logic last);
         match_result_type e;
         bit               full;
         int               ids[NumSearch];
         int               matched, win, win_count, c, pl, pr, base;
         if (act == ActClear) begin
            fill = 0;
            clear_dist();
            pos = 0;
            overlong = 0;
            return;
         end
         if (act == ActSpare) return;
         if (act == ActLoad) begin
            full = fill >= PoolSize;
            if (pos >= DescMax) overlong = 1;
            else begin
               if (!full) begin
                  pool_l[fill*DescMax+pos] = lv;
                  pool_r[fill*DescMax+pos] = rv;
                  written[fill*DescMax+pos] = 1;
               end
               pos++;
            end
            if (!last) return;
            e.kind = KindLoad;
            e.accepted = 0;
            e.pool_index = full ? 6'd0 : fill[5:0];
            e.vote_count = 0;
            e.searches_matched = 0;
            e.status = full ? StFull : (overlong ? StLong : StOk);
            exp_q = {exp_q, e};
            if (!full) fill++;
            pos = 0;
            overlong = 0;
            return;
         end
         // query element: accumulate all four distances per entry
         if (pos == 0) clear_dist();
         if (pos >= DescMax) overlong = 1;
         else begin
            for (int j = 0; j < PoolSize; j++) begin
               pl = pool_l[j*DescMax+pos];
               pr = pool_r[j*DescMax+pos];
               base = j * NumSearch;
               acc_sum[base]   += sq(lv, pl);
               acc_sum[base+1] += sq(lv, pr);
               acc_sum[base+2] += sq(rv, pl);
               acc_sum[base+3] += sq(rv, pr);
            end
            pos++;
         end
         if (!last) return;
         matched = 0;
         for (int s = 0; s < NumSearch; s++) begin
            ids[s] = nearest(s);
            if (ids[s] >= 0) matched++;
         end
         // vote, lower index winning ties
         win = -1;
         win_count = 0;
         for (int s = 0; s < NumSearch; s++) begin
            if (ids[s] >= 0) begin
               c = 0;
               for (int t = 0; t < NumSearch; t++) if (ids[t] == ids[s]) c++;
               if (c > win_count || (c == win_count && ids[s] < win)) begin
                  win = ids[s];
                  win_count = c;
               end
            end
         end
         e.kind = KindQuery;
         e.accepted = (matched >= 2 && win_count * 2 > matched);
         e.pool_index = (win >= 0) ? win[5:0] : 6'd0;
         e.vote_count = win_count[2:0];
         e.searches_matched = matched[2:0];
         e.status = overlong ? StLong : StOk;
         exp_q = {exp_q, e};
         clear_dist();
         pos = 0;
         overlong = 0;
      endfunction

      task check(logic [15:0] data, logic user);
         match_result_type e;
         if (exp_q.size() == 0) begin
            report("unexpected result", data, 0);
            return;
         end
         e = exp_q.pop_front();
         if (user !== e.kind) report("kind", user, e.kind);
         if (data[0] !== e.accepted) report("accepted", data[0], e.accepted);
         if (data[6:1] !== e.pool_index) report("pool_index", data[6:1], e.pool_index);
         if (data[9:7] !== e.vote_count) report("vote_count", data[9:7], e.vote_count);
         if (data[12:10] !== e.searches_matched)
            report("searches_matched", data[12:10], e.searches_matched);
         if (data[14:13] !== e.status) report("status", data[14:13], e.status);
         if (data[15] !== 1'b0) report("pad bit", data[15], 0);
      endtask
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;
   logic [1:0]  req_tuser = ActSpare;
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;
   logic        rsp_tuser;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [15:0] csr_data = '0;

   match_scoreboard sb;
   int  burst_left = 0;
   bit  no_gaps = 0;
   bit  hold_req = 0;
   int  sent = 0;
   int  idle_cycles = 0;

   descriptor_pool_ratio_match_vote u_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .req_tuser(req_tuser), .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function logic [11:0] clamp12(int v);
      if (v > 2047) return 12'sd2047;
      if (v < -2048) return -12'sd2048;
      return v[11:0];
   endfunction

   // Offer one request, with random gaps between bursts
   task send_req(logic [1:0] act, logic [11:0] lv, logic [11:0] rv, logic last);
      int gap;
      if (burst_left == 0) begin
         gap = (no_gaps || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 16);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {rv, lv};
      req_tuser  <= act;
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note(act, lv, rv, last);
      burst_left--;
      sent++;
   endtask

   // Hold the input low until every result is in, then let the pipe settle
   task drain();
      req_tvalid <= 1'b0;
      burst_left = 0;
      while (sb.exp_q.size() != 0) @(posedge clock);
      repeat (DrainWait) @(posedge clock);
   endtask

   task write_ratio(logic [15:0] v);
      drain();
      csr_valid <= 1'b1;
      csr_data  <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      sb.ratio = v;
   endtask

   // mode 0 random, mode 1 right close to left
   task load_entry(int len, int mode);
      logic [11:0] lv, rv;
      for (int p = 0; p < len; p++) begin
         lv = 12'($urandom);
         rv = (mode == 1) ? clamp12($signed(lv) + int'($urandom_range(0, 40)) - 20)
                          : 12'($urandom);
         send_req(ActLoad, lv, rv, p == len - 1);
      end
   endtask

   // Query near entry k, optionally with the sides swapped
   task query_near(int k, int len, int amp, bit swap);
      logic [11:0] lv, rv, tmp;
      for (int p = 0; p < len; p++) begin
         if (sb.fill == 0) begin
            lv = 12'($urandom);
            rv = 12'($urandom);
         end else begin
            lv = clamp12(sb.pool_l[k*DescMax+p] + int'($urandom_range(0, 2*amp)) - amp);
            rv = clamp12(sb.pool_r[k*DescMax+p] + int'($urandom_range(0, 2*amp)) - amp);
         end
         if (swap) begin
            tmp = lv; lv = rv; rv = tmp;
         end
         send_req(ActQuery, lv, rv, p == len - 1);
      end
   endtask

   // Receiver: stall pattern in modes, or one long hold-off on request
   initial begin
      int mode, mcount;
      mode = 0;
      mcount = 0;
      forever begin
         @(posedge clock);
         if (hold_req) begin
            rsp_tready <= 1'b0;
            repeat (HoldCycles) @(posedge clock);
            hold_req = 0;
         end else begin
            if (mcount == 0) begin
               mode = $urandom_range(0, 2);
               mcount = $urandom_range(20, 120);
            end
            mcount--;
            case (mode)
               0: rsp_tready <= 1'b1;
               1: rsp_tready <= 1'($urandom_range(0, 1));
               default: rsp_tready <= ($urandom_range(0, 3) == 0);
            endcase
         end
      end
   end

   // Check results and watch for a stuck block
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) sb.check(rsp_tdata, rsp_tuser);
         if ((rsp_tvalid && rsp_tready) || (req_tvalid && req_tready) ||
             (csr_valid && csr_ready))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IdleLimit) begin
            $display("descriptor_pool_ratio_match_vote verification failed");
            $finish;
         end
      end
   end

   initial begin
      int nent, len, nq, ql, k, amp, target, phase;
      logic [15:0] ratios[6];
      sb = new();
      ratios = '{16'd27689, 16'd0, 16'd65535, 16'd1, 16'd32768, 16'd50000};
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      repeat (DrainWait) @(posedge clock);
      write_ratio(16'd27689);

      // empty pool, extreme values
      send_req(ActQuery, 12'h7FF, 12'h800, 1'b0);
      send_req(ActQuery, 12'h800, 12'h7FF, 1'b1);
      // single entry: no second neighbor
      send_req(ActLoad, 12'h7FF, 12'h800, 1'b0);
      send_req(ActLoad, 12'h800, 12'h7FF, 1'b1);
      query_near(0, 2, 0, 0);
      write_ratio(16'd0);
      query_near(0, 2, 0, 0);
      write_ratio(16'd27689);
      // identical second entry: equal distances fail
      query_near(0, 2, 0, 0);
      send_req(ActLoad, 12'h7FF, 12'h800, 1'b0);
      send_req(ActLoad, 12'h800, 12'h7FF, 1'b1);
      query_near(0, 2, 0, 0);
      send_req(ActSpare, 12'h123, 12'h456, 1'b1);
      // mirrored entries: two-two vote tie, lower index wins, not accepted
      send_req(ActClear, 12'h000, 12'h000, 1'b0);
      send_req(ActLoad, 12'd100, 12'd1500, 1'b0);
      send_req(ActLoad, -12'sd300, -12'sd900, 1'b1);
      send_req(ActLoad, 12'd1500, 12'd100, 1'b0);
      send_req(ActLoad, -12'sd900, -12'sd300, 1'b1);
      query_near(0, 2, 0, 0);
      // overlong load and query
      send_req(ActClear, 12'h000, 12'h000, 1'b1);
      load_entry(DescMax + 2, 0);
      load_entry(DescMax, 1);
      query_near(1, DescMax + 2, 8, 0);
      // full pool drops the load
      send_req(ActClear, 12'h000, 12'h000, 1'b0);
      for (int j = 0; j <= PoolSize; j++) load_entry(1, $urandom_range(0, 1));
      query_near($urandom_range(0, PoolSize - 1), 1, 0, 0);

      // random phases with short descriptors
      target = 950;
      phase = 0;
      while (sent < target) begin
         write_ratio((phase < 6) ? ratios[phase] : 16'($urandom));
         no_gaps = ($urandom_range(0, 3) == 0);
         if (phase == 1) hold_req = 1;
         send_req(ActClear, 12'($urandom), 12'($urandom), 1'($urandom));
         nent = $urandom_range(1, 10);
         len = $urandom_range(1, 6);
         for (int j = 0; j < nent; j++)
            load_entry(($urandom_range(0, 3) == 0) ? $urandom_range(1, 8) : len,
                       $urandom_range(0, 1));
         nq = $urandom_range(4, 12);
         for (int q = 0; q < nq; q++) begin
            if (sb.safe_len() == 0)
               send_req(ActClear, 12'($urandom), 12'($urandom), 1'($urandom));
            ql = $urandom_range(1, (sb.safe_len() < 8) ? sb.safe_len() : 8);
            k = (sb.fill > 0) ? $urandom_range(0, sb.fill - 1) : 0;
            case ($urandom_range(0, 3))
               0: amp = 0;
               1: amp = 4;
               2: amp = 64;
               default: amp = 600;
            endcase
            if ($urandom_range(0, 7) == 0) query_near(k, ql, 2048, 0);
            else query_near(k, ql, amp, 1'($urandom_range(0, 1)));
            // noise: ignored requests, stray query elements, extra loads
            case ($urandom_range(0, 7))
               0: send_req(ActSpare, 12'($urandom), 12'($urandom), 1'($urandom));
               1: begin
                  send_req(ActQuery, 12'($urandom), 12'($urandom), 1'b0);
                  send_req(ActClear, 12'($urandom), 12'($urandom), 1'($urandom));
               end
               2: load_entry($urandom_range(1, 8), $urandom_range(0, 1));
               default: ;
            endcase
         end
         phase++;
      end

      drain();
      if (sb.errors == 0 && sb.exp_q.size() == 0)
         $display("descriptor_pool_ratio_match_vote verification clean");
      else
         $display("descriptor_pool_ratio_match_vote verification failed");
      $finish;
   end

endmodule
